[rtl/core/mrlm_pkg.sv]
`timescale 1ns / 1ps

package mrlm_pkg;

  localparam int PAT_COUNT   = 8;
  localparam int PAT_CONNECT = 7;
  localparam int PAT_CHARS   = 12;

  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_ZERO = 8'h30;

  typedef enum logic [1:0] {
    MODE_START = 2'd0,
    MODE_BYTE  = 2'd1,
    MODE_TICK  = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_MATCH    = 2'd0,
    ST_KNOWN    = 2'd1,
    ST_TIMEOUT  = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_t;

  localparam logic [1:0] KIND_ANY     = 2'd0;
  localparam logic [1:0] KIND_OK      = 2'd1;
  localparam logic [1:0] KIND_CONNECT = 2'd2;

  localparam logic [1:0] REG_EXPECTED_KIND = 2'd0;
  localparam logic [1:0] REG_TIMEOUT_TICKS = 2'd1;
  localparam logic [1:0] REG_LINE_LIMIT    = 2'd2;

  localparam logic [2:0] CODE_OK   = 3'd0;
  localparam logic [2:0] CODE_NONE = 3'd7;

  // Each text is right-justified: its last character sits in the lowest byte.
  localparam logic [8*PAT_CHARS-1:0] PAT_STR [PAT_COUNT] = '{
    "OK", "ERROR", "BUSY", "NO CARRIER",
    "NO DIALTONE", "NO ANSWER", "NO DIAL TONE", "CONNECT"
  };

  localparam logic [7:0] PAT_LEN [PAT_COUNT] = '{
    8'd2, 8'd5, 8'd4, 8'd10, 8'd11, 8'd9, 8'd12, 8'd7
  };

  typedef struct packed {
    logic clear;
    logic shift;
  } cell_ctl_t;

  // Character that lies pos places before the last one of pattern p.
  function automatic logic [7:0] pat_byte(input int p, input int pos);
    logic [7:0] ch;
    ch = 8'h00;
    if (pos < PAT_CHARS) begin
      ch = PAT_STR[p][8*pos +: 8];
    end
    return ch;
  endfunction

endpackage

[rtl/core/mrlm_ifs.sv]
`timescale 1ns / 1ps

interface mrlm_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] rx_byte;

  modport source (output valid, output mode, output rx_byte, input ready);
  modport sink (input valid, input mode, input rx_byte, output ready);
endinterface

interface mrlm_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [2:0] result_code;
  logic [7:0] line_length;

  modport source (output valid, output status, output result_code, output line_length,
                  input ready);
  modport sink (input valid, input status, input result_code, input line_length,
                output ready);
endinterface

interface mrlm_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [7:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[rtl/core/mrlm_cell.sv]
`timescale 1ns / 1ps

module mrlm_cell import mrlm_pkg::*; #(
  parameter int IDX = 0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cell_ctl_t            ctl,
  input  logic [7:0]           byte_in,
  output logic [7:0]           byte_out,
  output logic [PAT_COUNT-1:0] hit
);

  logic [7:0] byte_r;
  logic [7:0] byte_nxt;

  always_comb begin
    byte_nxt = byte_r;
    if (ctl.clear) begin
      byte_nxt = 8'h00;
    end else if (ctl.shift) begin
      byte_nxt = byte_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_r <= 8'h00;
    end else begin
      byte_r <= byte_nxt;
    end
  end

  // A pattern no longer than this cell's distance from the newest byte does not reach it.
  always_comb begin
    for (int p = 0; p < PAT_COUNT; p++) begin
      if (IDX + 1 >= int'(PAT_LEN[p])) begin
        hit[p] = 1'b1;
      end else begin
        hit[p] = (byte_r == pat_byte(p, IDX + 1));
      end
    end
  end

  assign byte_out = byte_r;

endmodule

[rtl/core/modem_result_line_matcher_top.sv]
`timescale 1ns / 1ps

// Modem result line matcher. Each request carries a mode (start a new wait, a received
// byte, or an empty one-second read tick), and requests may arrive back to back; a result,
// when the wait ends, appears in the output register on the cycle after the request that
// caused it. New requests are held off while a result waits to be collected, and a result
// collected in a given cycle frees the input in that same cycle. The recent line bytes sit
// in a row of HISTORY_BYTES cells that shift once per stored line byte and compare
// themselves against every known text at once, all combinationally. Configuration is
// taken at any time and should be written while idle.
module modem_result_line_matcher_top import mrlm_pkg::*; #(
  parameter int HISTORY_BYTES = 11
) (
  input logic           clk,
  input logic           rst_n,
  mrlm_in_if.sink       in_req,
  mrlm_out_if.source    out_res,
  mrlm_cfg_if.sink      cfg_wr
);

  logic [1:0] kind_r;
  logic [7:0] timeout_r;
  logic [7:0] limit_r;

  logic [7:0] count_r, count_nxt;
  logic [8:0] tick_r, tick_nxt;
  logic [PAT_COUNT-1:0] seen_r, seen_nxt;
  logic zero_r, zero_nxt;
  logic done_r, done_nxt;

  logic       out_valid_r, out_valid_nxt;
  logic [1:0] status_r, status_nxt;
  logic [2:0] code_r, code_nxt;
  logic [7:0] length_r, length_nxt;

  cell_ctl_t            ctl;
  logic                 accept;
  logic                 emit;
  logic [7:0]           win [HISTORY_BYTES];
  logic [PAT_COUNT-1:0] cell_hit [HISTORY_BYTES];
  logic [PAT_COUNT-1:0] hit_all;
  logic [PAT_COUNT-1:0] ends_here;
  logic                 match;
  logic                 known;
  logic [2:0]           known_code;
  logic [7:0]           count_inc;

  assign cfg_wr.ready = 1'b1;
  assign in_req.ready = !out_valid_r || out_res.ready;
  assign accept       = in_req.valid && in_req.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r    <= KIND_OK;
      timeout_r <= 8'd3;
      limit_r   <= 8'd100;
    end else if (cfg_wr.valid) begin
      case (cfg_wr.index)
        REG_EXPECTED_KIND: kind_r    <= cfg_wr.data[1:0];
        REG_TIMEOUT_TICKS: timeout_r <= cfg_wr.data;
        REG_LINE_LIMIT:    limit_r   <= cfg_wr.data;
        default: ;
      endcase
    end
  end

  for (genvar i = 0; i < HISTORY_BYTES; i++) begin : g_cell
    logic [7:0] feed;
    if (i == 0) begin : g_head
      assign feed = in_req.rx_byte;
    end else begin : g_link
      assign feed = win[i-1];
    end
    mrlm_cell #(.IDX(i)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .byte_in  (feed),
      .byte_out (win[i]),
      .hit      (cell_hit[i])
    );
  end

  always_comb begin
    hit_all = '1;
    for (int i = 0; i < HISTORY_BYTES; i++) begin
      hit_all = hit_all & cell_hit[i];
    end
    for (int p = 0; p < PAT_COUNT; p++) begin
      ends_here[p] = hit_all[p] && (in_req.rx_byte == pat_byte(p, 0))
                     && (int'(PAT_LEN[p]) - 1 <= HISTORY_BYTES);
    end
  end

  always_comb begin
    case (kind_r)
      KIND_OK:      match = seen_r[0] || zero_r;
      KIND_CONNECT: match = seen_r[PAT_CONNECT];
      default:      match = 1'b1;
    endcase
    known      = 1'b0;
    known_code = CODE_OK;
    for (int p = PAT_CONNECT - 1; p >= 0; p--) begin
      if (seen_r[p]) begin
        known      = 1'b1;
        known_code = 3'(p);
      end
    end
  end

  assign count_inc = count_r + 8'd1;

  always_comb begin
    count_nxt  = count_r;
    tick_nxt   = tick_r;
    seen_nxt   = seen_r;
    zero_nxt   = zero_r;
    done_nxt   = done_r;
    ctl        = '0;
    emit       = 1'b0;
    status_nxt = status_r;
    code_nxt   = code_r;
    length_nxt = length_r;

    if (accept) begin
      if (in_req.mode == MODE_START) begin
        ctl.clear = 1'b1;
        count_nxt = 8'd0;
        seen_nxt  = '0;
        zero_nxt  = 1'b0;
        tick_nxt  = 9'd0;
        done_nxt  = 1'b0;
      end else if (!done_r && in_req.mode == MODE_TICK) begin
        tick_nxt = tick_r + 9'd1;
        if (tick_nxt > {1'b0, timeout_r}) begin
          emit       = 1'b1;
          status_nxt = ST_TIMEOUT;
          code_nxt   = CODE_NONE;
          length_nxt = count_r;
        end
      end else if (!done_r && in_req.mode == MODE_BYTE) begin
        if (count_r == 8'd0 && (in_req.rx_byte == CH_CR || in_req.rx_byte == CH_LF)) begin
          ctl = '0;
        end else if (in_req.rx_byte == CH_CR) begin
          if (match) begin
            emit       = 1'b1;
            status_nxt = ST_MATCH;
            code_nxt   = CODE_NONE;
            length_nxt = count_r;
          end else if (known) begin
            emit       = 1'b1;
            status_nxt = ST_KNOWN;
            code_nxt   = known_code;
            length_nxt = PAT_LEN[known_code];
          end else if (zero_r) begin
            emit       = 1'b1;
            status_nxt = ST_KNOWN;
            code_nxt   = CODE_OK;
            length_nxt = 8'd2;
          end else begin
            ctl.clear = 1'b1;
            count_nxt = 8'd0;
            seen_nxt  = '0;
            zero_nxt  = 1'b0;
          end
        end else begin
          ctl.shift = 1'b1;
          seen_nxt  = seen_r | ends_here;
          zero_nxt  = (count_r == 8'd0) && (in_req.rx_byte == CH_ZERO);
          count_nxt = count_inc;
          if ({1'b0, count_inc} + 9'd2 > {1'b0, limit_r}) begin
            emit       = 1'b1;
            status_nxt = ST_OVERFLOW;
            code_nxt   = CODE_NONE;
            length_nxt = count_inc;
          end
        end
      end
      if (emit) begin
        done_nxt = 1'b1;
      end
    end

    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_res.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= 8'd0;
      tick_r      <= 9'd0;
      seen_r      <= '0;
      zero_r      <= 1'b0;
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      tick_r      <= tick_nxt;
      seen_r      <= seen_nxt;
      zero_r      <= zero_nxt;
      done_r      <= done_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    code_r   <= code_nxt;
    length_r <= length_nxt;
  end

  assign out_res.valid       = out_valid_r;
  assign out_res.status      = status_r;
  assign out_res.result_code = code_r;
  assign out_res.line_length = length_r;

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import mrlm_pkg::*;

  localparam int HIST = 11;
  localparam int CFG_QUIET = 4;
  localparam logic [1:0] KIND_SPARE = 2'd3;

  typedef struct packed {
    status_t    status;
    logic [2:0] code;
    logic [7:0] len;
  } line_res_t;

  typedef struct {
    bit         is_cfg;
    logic [1:0] sel;
    logic [7:0] val;
  } request_t;

  logic clk = 1'b0;
  logic rst_n;

  mrlm_in_if  in_req ();
  mrlm_out_if out_res ();
  mrlm_cfg_if cfg_wr ();

  modem_result_line_matcher_top DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_res (out_res),
    .cfg_wr  (cfg_wr)
  );

  request_t  pending_q[$];
  line_res_t expected_q[$];
  int        mismatches = 0;
  int        n_queued = 0;
  logic      nothing_expected = 1'b1;

  logic [1:0] kind_reg = KIND_OK;
  logic [7:0] ticks_reg = 8'd3;
  logic [7:0] limit_reg = 8'd100;
  logic [7:0] hist [HIST] = '{default: 8'h00};
  logic [7:0] n_bytes = 8'd0;
  logic [8:0] n_ticks = 9'd0;
  logic [7:0] seen = 8'd0;
  logic       zero_line = 1'b0;
  logic       wait_over = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic string code_text(int p);
    case (p)
      0: return "OK";
      1: return "ERROR";
      2: return "BUSY";
      3: return "NO CARRIER";
      4: return "NO DIALTONE";
      5: return "NO ANSWER";
      6: return "NO DIAL TONE";
      default: return "CONNECT";
    endcase
  endfunction

  function automatic void clear_line();
    foreach (hist[i]) hist[i] = 8'h00;
    n_bytes = 8'd0;
    seen = 8'd0;
    zero_line = 1'b0;
  endfunction

  function automatic void predict_line(input logic [1:0] mode, input logic [7:0] b,
                                       output bit got, output line_res_t res);
    string t;
    int    n;
    bit    hit;
    got = 1'b0;
    res = '0;
    if (mode == MODE_START) begin
      clear_line();
      n_ticks = 9'd0;
      wait_over = 1'b0;
    end else if (wait_over || mode == MODE_NONE) begin
    end else if (mode == MODE_TICK) begin
      n_ticks = n_ticks + 9'd1;
      if (n_ticks > {1'b0, ticks_reg}) begin
        got = 1'b1;
        res = '{ST_TIMEOUT, CODE_NONE, n_bytes};
      end
    end else if (n_bytes == 8'd0 && (b == CH_CR || b == CH_LF)) begin
    end else if (b == CH_CR) begin
      if (kind_reg == KIND_OK) begin
        hit = seen[0] || zero_line;
      end else if (kind_reg == KIND_CONNECT) begin
        hit = seen[PAT_CONNECT];
      end else begin
        hit = 1'b1;
      end
      if (hit) begin
        got = 1'b1;
        res = '{ST_MATCH, CODE_NONE, n_bytes};
      end
      // The first known code in table order wins.
      for (int p = 0; p < PAT_CONNECT; p++) begin
        if (!got && seen[p]) begin
          t = code_text(p);
          got = 1'b1;
          res = '{ST_KNOWN, 3'(p), 8'(t.len())};
        end
      end
      if (!got && zero_line) begin
        got = 1'b1;
        res = '{ST_KNOWN, CODE_OK, 8'd2};
      end
      if (!got) clear_line();
    end else begin
      for (int p = 0; p < PAT_COUNT; p++) begin
        t = code_text(p);
        n = t.len();
        hit = (n - 1 <= HIST) && (int'(n_bytes) + 1 >= n) && (t[n-1] == b);
        for (int k = 1; k < n; k++) begin
          if (hit && hist[k-1] != t[n-1-k]) hit = 1'b0;
        end
        if (hit) seen[p] = 1'b1;
      end
      zero_line = (n_bytes == 8'd0 && b == CH_ZERO);
      for (int k = HIST - 1; k > 0; k--) hist[k] = hist[k-1];
      hist[0] = b;
      n_bytes = n_bytes + 8'd1;
      if (int'(n_bytes) + 2 > int'(limit_reg)) begin
        got = 1'b1;
        res = '{ST_OVERFLOW, CODE_NONE, n_bytes};
      end
    end
    if (got) wait_over = 1'b1;
  endfunction

  function automatic int draw_wait(bit calm);
    return calm ? 0 : $urandom_range(0, 4);
  endfunction

  function automatic void add_req(logic [1:0] mode, logic [7:0] b);
    request_t r;
    r.is_cfg = 1'b0;
    r.sel = mode;
    r.val = b;
    pending_q.push_back(r);
    n_queued++;
  endfunction

  function automatic void add_cfg(logic [1:0] idx, logic [7:0] data);
    request_t r;
    r.is_cfg = 1'b1;
    r.sel = idx;
    r.val = data;
    pending_q.push_back(r);
  endfunction

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) add_req(MODE_BYTE, s[i]);
  endfunction

  function automatic void add_noise(int n);
    logic [7:0] b;
    repeat (n) begin
      do b = 8'($urandom); while (b == CH_CR);
      add_req(MODE_BYTE, b);
    end
  endfunction

  // One wait: a start, then mostly well-formed lines with random content.
  function automatic void add_wait(int to_cfg, int lim_cfg);
    string t;
    int    shape;
    add_req(MODE_START, 8'($urandom));
    repeat ($urandom_range(0, 2)) add_req(MODE_BYTE, $urandom_range(0, 1) ? CH_CR : CH_LF);
    shape = $urandom_range(0, 9);
    if (shape == 0 && to_cfg <= 24) begin
      repeat (to_cfg + 1) add_req(MODE_TICK, 8'($urandom));
    end else if (shape == 1 && lim_cfg <= 40) begin
      add_noise(lim_cfg > 3 ? lim_cfg - 3 + $urandom_range(0, 2) : $urandom_range(0, 2));
      add_req(MODE_BYTE, CH_CR);
    end else begin
      repeat ($urandom_range(1, 3)) begin
        t = code_text($urandom_range(0, PAT_COUNT - 1));
        case ($urandom_range(0, 7))
          0: add_text(t);
          1: begin
            add_noise($urandom_range(0, 3));
            add_text(t);
            add_noise($urandom_range(0, 3));
          end
          2: add_text("0");
          3: add_noise($urandom_range(1, 6));
          4: begin
            add_text("0");
            add_noise($urandom_range(1, 2));
          end
          5: add_text(t.substr(0, t.len() - 2));
          6: begin
            repeat ($urandom_range(1, 3)) add_req(MODE_TICK, 8'($urandom));
            add_text(t);
          end
          default: begin
            add_req(MODE_NONE, 8'($urandom));
            add_noise($urandom_range(0, 2));
            if ($urandom_range(0, 1) == 1) add_req(MODE_START, 8'($urandom));
            add_text(t);
          end
        endcase
        if ($urandom_range(0, 3) == 0) add_req(MODE_BYTE, CH_LF);
        add_req(MODE_BYTE, CH_CR);
      end
    end
    if ($urandom_range(0, 3) == 0) begin
      add_noise(1);
      add_req(MODE_TICK, 8'($urandom));
    end
  endfunction

  int in_gap = 0;
  int quiet = 0;
  bit in_calm = 1'b0;

  always @(posedge clk) begin
    request_t r;
    bit       send_req;
    bit       send_cfg;
    if (!rst_n) begin
      in_req.valid <= 1'b0;
      in_req.mode <= MODE_START;
      in_req.rx_byte <= 8'h00;
      cfg_wr.valid <= 1'b0;
      cfg_wr.index <= REG_EXPECTED_KIND;
      cfg_wr.data <= 8'h00;
    end else if (!(in_req.valid && !in_req.ready) && !(cfg_wr.valid && !cfg_wr.ready)) begin
      send_req = 1'b0;
      send_cfg = 1'b0;
      if (in_req.valid || cfg_wr.valid || !nothing_expected) begin
        quiet = 0;
      end else if (quiet < CFG_QUIET) begin
        quiet++;
      end
      if ($urandom_range(0, 39) == 0) in_calm = !in_calm;
      if (in_gap > 0) begin
        in_gap--;
      end else if (pending_q.size() != 0) begin
        if (!pending_q[0].is_cfg) begin
          r = pending_q.pop_front();
          send_req = 1'b1;
          in_req.mode <= r.sel;
          in_req.rx_byte <= r.val;
          in_gap = draw_wait(in_calm);
        end else if (quiet >= CFG_QUIET) begin
          // Registers change only once the block has settled.
          r = pending_q.pop_front();
          send_cfg = 1'b1;
          cfg_wr.index <= r.sel;
          cfg_wr.data <= r.val;
          quiet = 0;
        end
      end
      in_req.valid <= send_req;
      cfg_wr.valid <= send_cfg;
    end
  end

  int out_stall = 0;
  bit out_calm = 1'b0;

  always @(posedge clk) begin
    line_res_t want;
    line_res_t res;
    bit        got;
    if (!rst_n) begin
      out_res.ready <= 1'b0;
    end else begin
      if (out_res.valid && out_res.ready) begin
        if (expected_q.size() == 0) begin
          $error("result with none expected: status %0d, result_code %0d, line_length %0d",
                 out_res.status, out_res.result_code, out_res.line_length);
          mismatches++;
        end else begin
          want = expected_q.pop_front();
          if (out_res.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_res.status);
            mismatches++;
          end
          if (out_res.result_code !== want.code) begin
            $error("result_code: expected %0d, got %0d", want.code, out_res.result_code);
            mismatches++;
          end
          if (out_res.line_length !== want.len) begin
            $error("line_length: expected %0d, got %0d", want.len, out_res.line_length);
            mismatches++;
          end
        end
        if ($urandom_range(0, 7) == 0) out_calm = !out_calm;
        out_stall = draw_wait(out_calm);
      end else if (out_stall > 0) begin
        out_stall--;
      end
      out_res.ready <= (out_stall == 0);
      if (cfg_wr.valid && cfg_wr.ready) begin
        case (cfg_wr.index)
          REG_EXPECTED_KIND: kind_reg = cfg_wr.data[1:0];
          REG_TIMEOUT_TICKS: ticks_reg = cfg_wr.data;
          REG_LINE_LIMIT:    limit_reg = cfg_wr.data;
          default: ;
        endcase
      end
      if (in_req.valid && in_req.ready) begin
        predict_line(in_req.mode, in_req.rx_byte, got, res);
        if (got) expected_q.push_back(res);
      end
      nothing_expected <= (expected_q.size() == 0);
    end
  end

  initial begin
    int         to_cfg;
    int         lim_cfg;
    logic [1:0] kind;
    rst_n = 1'b0;

    // Skipped leading CR and LF, then a plain OK under the reset settings.
    add_req(MODE_BYTE, CH_LF);
    add_req(MODE_BYTE, CH_CR);
    add_text("OK");
    add_req(MODE_BYTE, CH_CR);
    // A bare zero counts as OK; the byte after it is ignored as the wait is over.
    add_req(MODE_START, 8'hFF);
    add_text("0");
    add_req(MODE_BYTE, CH_CR);
    add_text("Z");
    add_req(MODE_START, 8'h00);
    repeat (4) add_req(MODE_TICK, 8'hA5);
    // An unused mode is ignored, and NUL and all-ones bytes are ordinary characters.
    add_req(MODE_START, 8'h5A);
    add_req(MODE_NONE, 8'hFF);
    add_req(MODE_BYTE, 8'h00);
    add_text("BUSY");
    add_req(MODE_BYTE, 8'hFF);
    add_req(MODE_BYTE, CH_CR);

    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: begin
          kind = KIND_CONNECT;
          to_cfg = 0;
          lim_cfg = 255;
        end
        1: begin
          kind = KIND_ANY;
          to_cfg = 255;
          lim_cfg = 3;
        end
        2: begin
          kind = KIND_SPARE;
          to_cfg = 1;
          lim_cfg = 0;
        end
        3: begin
          kind = KIND_OK;
          to_cfg = 8;
          lim_cfg = 2;
        end
        default: begin
          kind = 2'($urandom_range(0, 3));
          to_cfg = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 255) : $urandom_range(0, 8);
          lim_cfg = ($urandom_range(0, 1) == 1) ? $urandom_range(3, 40) : $urandom_range(41, 255);
        end
      endcase
      add_cfg(REG_EXPECTED_KIND, {6'd0, kind});
      add_cfg(REG_TIMEOUT_TICKS, 8'(to_cfg));
      add_cfg(REG_LINE_LIMIT, 8'(lim_cfg));
      if (ph == 0) begin
        add_req(MODE_START, 8'h00);
        add_text("X");
        add_noise(253);
      end
      if (ph == 1) begin
        add_req(MODE_START, 8'h00);
        repeat (256) add_req(MODE_TICK, 8'($urandom));
      end
      while (n_queued < 25 + (ph + 1) * 88) add_wait(to_cfg, lim_cfg);
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    do @(posedge clk);
    while (pending_q.size() != 0 || in_req.valid || cfg_wr.valid || expected_q.size() != 0);
    repeat (8) @(posedge clk);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

endmodule

[files.f]
rtl/core/mrlm_pkg.sv
rtl/core/mrlm_ifs.sv
rtl/core/mrlm_cell.sv
rtl/core/modem_result_line_matcher_top.sv
tb/sv/testbench.sv
